/* rtl/bms_pkg.sv */
// Types, constant tables and small helpers for the buzzer melody sequencer.
// Used by buzzer_melody_sequencer; no dependencies of its own.
package bms_pkg;

	localparam int IDX_W     = 7;
	localparam int ENTRY_W   = 14;
	localparam int ELAPSED_W = 22;
	localparam int PERIOD_W  = 19;
	localparam int COMPARE_W = 18;

	localparam logic [PERIOD_W-1:0]  PERIOD_REST = 19'd499999;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 22'd4194303;
	localparam logic [15:0]          TICK_US_RST = 16'd5000;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Beat length per beat index, already in microseconds.
	localparam logic [ELAPSED_W-1:0] BEAT_US [0:6] = '{
		22'd0, 22'd62000, 22'd94000, 22'd125000, 22'd125000, 22'd187000, 22'd250000
	};

	// 500000 / freq - 1 per octave and tone; tone 0 is a rest.
	localparam logic [PERIOD_W-1:0] TONE_PERIOD [0:2][0:7] = '{
		'{19'd499999, 19'd1914, 19'd1705, 19'd1518, 19'd1431, 19'd1277, 19'd1135, 19'd1013},
		'{19'd499999, 19'd955,  19'd850,  19'd757,  19'd715,  19'd637,  19'd567,  19'd505},
		'{19'd499999, 19'd477,  19'd424,  19'd378,  19'd357,  19'd318,  19'd283,  19'd252}
	};

	typedef struct packed {
		logic       req_type;
		logic       enable;
		logic [5:0] first_note;
		logic [6:0] end_note;
		logic [5:0] note_addr;
		logic [6:0] pitch_code;
		logic [6:0] length_code;
	} in_item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  timer_period;
		logic [COMPARE_W-1:0] timer_compare;
		logic                 tone_update;
		logic                 playing;
	} out_item_t;

	// Tens digit of a 7-bit value: x * 205 >> 11 is exact below 1029.
	function automatic logic [3:0] div10(input logic [6:0] x);
		logic [14:0] prod;
		prod = {8'd0, x} * 15'd205;
		return prod[14:11];
	endfunction

	// Octave clamped to 2, tones outside 1..7 rest.
	function automatic logic [PERIOD_W-1:0] tone_period(input logic [3:0] octave,
		input logic [3:0] tone);
		logic [1:0] oct;
		oct = (octave > 4'd2) ? 2'd2 : octave[1:0];
		if (tone == 4'd0 || tone > 4'd7) begin
			return PERIOD_REST;
		end
		return TONE_PERIOD[oct][tone[2:0]];
	endfunction

endpackage

/* rtl/buzzer_melody_sequencer.sv */
// Buzzer melody sequencer: note store in a RAM, tick-driven playback control.
// An accepted beat's result is registered into the output register.
// Throughput: one item per cycle while the output is not stalled; the note RAM is read ahead at the next note index.
// Reset clears playback state and restores tick_us to 5000; note entries stay
// undefined until written.
// Depends on bms_pkg and bms_ram.
module buzzer_melody_sequencer
	import bms_pkg::*;
#(
	parameter int NOTE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW  = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
	localparam int IXW = (AW > IDX_W) ? AW : IDX_W;
	localparam logic [IXW:0] DEPTH_LIM = (IXW+1)'(NOTE_DEPTH);

	logic [15:0]          tick_us_q;
	logic                 run_q, run_d;
	logic [IDX_W-1:0]     note_index_q, note_index_d;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
	logic                 out_valid_q;
	out_item_t            out_data_q, res;

	logic                 fwd_hit_q;
	logic [ENTRY_W-1:0]   fwd_data_q;
	logic [ENTRY_W-1:0]   rd_data, entry;

	logic                 in_fire;
	logic [IXW-1:0]       wr_addr_ext, idx_ext, idx_next_ext;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0]   ram_wdata;

	logic [6:0]           pitch, len, reps_full, tone_full;
	logic [3:0]           beat_raw, oct_raw;
	logic [2:0]           beat;
	logic [25:0]          limit_full;
	logic [ELAPSED_W-1:0] limit;
	logic [PERIOD_W-1:0]  note_period;
	logic [ELAPSED_W:0]   elapsed_sum;
	logic [ELAPSED_W-1:0] elapsed_sat;
	logic                 idx_done;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	// Note write path
	assign wr_addr_ext = IXW'(in_data.note_addr);
	assign ram_we      = in_fire && (in_data.req_type == REQ_WRITE)
		&& ({1'b0, wr_addr_ext} < DEPTH_LIM);
	assign ram_waddr   = wr_addr_ext[AW-1:0];
	assign ram_wdata   = {in_data.length_code, in_data.pitch_code};

	// Read ahead at the index the next beat will see
	assign idx_next_ext = IXW'(note_index_d);
	assign ram_raddr    = idx_next_ext[AW-1:0];

	bms_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NOTE_DEPTH)
	) u_note_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// RAM returns old data on a same-cycle write; take the written entry instead
	assign entry = fwd_hit_q ? fwd_data_q : rd_data;

	// Note decode
	assign pitch      = entry[6:0];
	assign len        = entry[13:7];
	assign beat_raw   = div10(len);
	assign reps_full  = len - 7'(beat_raw) * 7'd10;
	assign beat       = (beat_raw > 4'd6) ? 3'd6 : beat_raw[2:0];
	assign limit_full = BEAT_US[beat] * reps_full[3:0];
	assign limit      = limit_full[ELAPSED_W-1:0];
	assign oct_raw    = div10(pitch);
	assign tone_full  = pitch - 7'(oct_raw) * 7'd10;
	assign note_period = tone_period(oct_raw, tone_full[3:0]);

	assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W+1)'(tick_us_q);
	assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];

	assign idx_ext  = IXW'(note_index_q);
	assign idx_done = (note_index_q >= in_data.end_note) || ({1'b0, idx_ext} >= DEPTH_LIM);

	always_comb begin
		run_d        = run_q;
		note_index_d = note_index_q;
		elapsed_d    = elapsed_q;
		res          = '0;
		if (in_fire && in_data.req_type == REQ_TICK) begin
			priority if (!run_q) begin
				if (in_data.enable) begin
					run_d        = 1'b1;
					note_index_d = IDX_W'(in_data.first_note);
					elapsed_d    = '0;
				end
			end else if (!in_data.enable || idx_done) begin
				run_d             = 1'b0;
				res.tone_update   = 1'b1;
				res.timer_period  = PERIOD_REST;
				res.timer_compare = PERIOD_REST[PERIOD_W-1:1];
			end else if (elapsed_q > limit) begin
				note_index_d      = note_index_q + 1'b1;
				elapsed_d         = '0;
				res.tone_update   = 1'b1;
				res.timer_period  = note_period;
				res.timer_compare = note_period[PERIOD_W-1:1];
			end else begin
				elapsed_d = elapsed_sat;
			end
		end
		res.playing = run_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_us_q    <= TICK_US_RST;
			run_q        <= 1'b0;
			note_index_q <= '0;
			elapsed_q    <= '0;
			out_valid_q  <= 1'b0;
			fwd_hit_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tick_us_q <= cfg_data;
			end
			run_q        <= run_d;
			note_index_q <= note_index_d;
			elapsed_q    <= elapsed_d;
			fwd_hit_q    <= ram_we && (ram_waddr == ram_raddr);
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
		if (in_fire) begin
			out_data_q <= res;
		end
	end

	// A note write never disturbs playback state
	a_write_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.req_type == REQ_WRITE
		|=> run_q == $past(run_q) && note_index_q == $past(note_index_q)
			&& elapsed_q == $past(elapsed_q))
		else $error("note write changed playback state");

	// Dropping enable while playing silences and stops
	a_stop_silence: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.req_type == REQ_TICK && run_q && !in_data.enable
		|=> out_valid && out_data.tone_update && out_data.timer_period == PERIOD_REST
			&& !out_data.playing)
		else $error("enable drop did not silence");

	// Compare is always half the period, zero when nothing is issued
	a_compare_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.timer_compare == out_data.timer_period[PERIOD_W-1:1]
			&& (out_data.tone_update || out_data.timer_period == '0))
		else $error("period/compare mismatch");

	// Playing flag in the result tracks the run state after that beat
	a_playing_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_data.playing == run_q)
		else $error("playing flag out of step with run state");

	// Elapsed time is cleared whenever a tone is issued while playback continues
	a_elapsed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && res.tone_update && run_d |=> elapsed_q == '0)
		else $error("elapsed time not cleared on note advance");

endmodule

/* rtl/bms_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
module bms_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* verif/tb.sv */
// Self-checking testbench for buzzer_melody_sequencer: directed and random note
// writes and ticks, checked against a scoreboard that predicts every result beat.
// Depends on bms_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb;
	import bms_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 200;
	localparam int PHASE_BEATS = 200;

	class tone_scoreboard;
		localparam int DEPTH = 64;

		out_item_t   pending_tones[$];
		logic [13:0] notes [DEPTH];
		bit          written [DEPTH];
		bit          running;
		logic [6:0]  idx;
		int unsigned elapsed;
		int unsigned tick_us;
		int unsigned beat_ms [7];
		int unsigned freq [3][8];
		int          errors;

		function new();
			running = 0;
			idx     = '0;
			elapsed = 0;
			tick_us = 5000;
			errors  = 0;
			beat_ms = '{0, 62, 94, 125, 125, 187, 250};
			freq    = '{'{0, 261, 293, 329, 349, 391, 440, 493},
				'{0, 523, 587, 659, 698, 783, 880, 987},
				'{0, 1046, 1174, 1318, 1396, 1567, 1760, 1975}};
			foreach (written[i]) written[i] = 0;
		endfunction

		function int unsigned note_limit(logic [6:0] len);
			int unsigned b;
			b = len / 10;
			if (b > 6) b = 6;
			return beat_ms[b] * (len % 10) * 1000;
		endfunction

		// Notes that would need more than a few dozen ticks at the current tick length
		function bit too_slow(logic [6:0] len);
			return note_limit(len) / tick_us > 60;
		endfunction

		function bit readable(logic [5:0] a);
			return written[a] && !too_slow(notes[a][13:7]);
		endfunction

		function void note_beat(in_item_t it);
			out_item_t   r;
			logic [13:0] e;
			int unsigned oct, tone, per;
			r = '0;
			if (it.req_type == REQ_WRITE) begin
				notes[it.note_addr]   = {it.length_code, it.pitch_code};
				written[it.note_addr] = 1;
			end else if (!running) begin
				if (it.enable) begin
					running = 1;
					idx     = {1'b0, it.first_note};
					elapsed = 0;
				end
			end else if (!it.enable || idx >= it.end_note || idx >= DEPTH) begin
				running         = 0;
				r.timer_period  = PERIOD_REST;
				r.timer_compare = PERIOD_REST[PERIOD_W-1:1];
				r.tone_update   = 1;
			end else begin
				e = notes[idx[5:0]];
				if (elapsed > note_limit(e[13:7])) begin
					oct  = e[6:0] / 10;
					tone = e[6:0] % 10;
					if (oct > 2) oct = 2;
					if (tone == 0 || tone > 7) per = PERIOD_REST;
					else per = 500000 / freq[oct][tone] - 1;
					idx             = idx + 7'd1;
					elapsed         = 0;
					r.timer_period  = PERIOD_W'(per);
					r.timer_compare = COMPARE_W'(per / 2);
					r.tone_update   = 1;
				end else begin
					elapsed = elapsed + tick_us;
					if (elapsed > ELAPSED_MAX) elapsed = ELAPSED_MAX;
				end
			end
			r.playing = running;
			pending_tones.push_back(r);
		endfunction

		task report(string what);
			$display("MISMATCH @%0t: %s", $realtime, what);
			errors++;
		endtask

		task check_beat(out_item_t got);
			out_item_t want;
			if (pending_tones.size() == 0) begin
				report($sformatf("result beat with nothing pending: %p", got));
			end else begin
				want = pending_tones.pop_front();
				if (got.timer_period !== want.timer_period)
					report($sformatf("timer_period %0d, want %0d", got.timer_period,
						want.timer_period));
				if (got.timer_compare !== want.timer_compare)
					report($sformatf("timer_compare %0d, want %0d", got.timer_compare,
						want.timer_compare));
				if (got.tone_update !== want.tone_update)
					report($sformatf("tone_update %b, want %b", got.tone_update,
						want.tone_update));
				if (got.playing !== want.playing)
					report($sformatf("playing %b, want %b", got.playing, want.playing));
			end
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 0;
	out_item_t   out_data;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	tone_scoreboard sb;
	int burst_left = 0;
	int beats_sent = 0;
	int stall_cycles = 0;
	bit hold_request = 0;

	buzzer_melody_sequencer #(.NOTE_DEPTH(64)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_beat(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: stall pattern redrawn at random from four modes, one long hold on request
	initial begin
		int mode, hold, cyc;
		bit hold_seen;
		mode      = 0;
		hold      = 0;
		cyc       = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_seen) begin
				hold      = LONG_HOLD;
				hold_seen = 1;
			end
			if (cyc % 64 == 0) mode = $urandom_range(0, 3);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= (cyc % 4) != 0;
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (cyc % 5) == 0;
				endcase
			end
			cyc++;
		end
	end

	function automatic in_item_t mk(logic req, logic en, logic [5:0] first,
		logic [6:0] end_n, logic [5:0] addr, logic [6:0] pitch, logic [6:0] len);
		in_item_t it;
		it.req_type    = req;
		it.enable      = en;
		it.first_note  = first;
		it.end_note    = end_n;
		it.note_addr   = addr;
		it.pitch_code  = pitch;
		it.length_code = len;
		return it;
	endfunction

	function automatic logic [6:0] rand_pitch();
		return 7'(($urandom_range(0, 7) == 0) ? $urandom_range(100, 127) :
			$urandom_range(0, 99));
	endfunction

	// Long notes fall back to a zero repeat count so playback keeps moving
	function automatic logic [6:0] rand_length();
		int c;
		c = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 127) : $urandom_range(0, 99);
		if ($urandom_range(0, 1) == 0) c = c - c % 10 + $urandom_range(0, 2) % 10;
		if (c > 127) c = 127;
		if (sb.too_slow(7'(c))) c = c - c % 10;
		return 7'(c);
	endfunction

	function automatic in_item_t rand_item();
		return mk(($urandom_range(0, 3) == 0) ? REQ_WRITE : REQ_TICK,
			$urandom_range(0, 9) != 0, 6'($urandom),
			7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) :
				$urandom_range(0, 64)),
			6'($urandom), rand_pitch(), rand_length());
	endfunction

	// A tick that would read an unwritten or overly long note ends playback instead
	function automatic in_item_t guard_read(in_item_t it);
		if (it.req_type == REQ_TICK && it.enable && sb.running && sb.idx < it.end_note &&
			sb.idx < 64 && !sb.readable(sb.idx[5:0]))
			it.end_note = 7'($urandom_range(0, sb.idx));
		return it;
	endfunction

	task automatic send_beat(input in_item_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(it);
	endtask

	task automatic push_item(input in_item_t it);
		int g;
		it = guard_read(it);
		if (!(it.req_type == REQ_TICK && !it.enable && !sb.running)) beats_sent++;
		send_beat(it);
		burst_left--;
		if (burst_left <= 0) begin
			g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_tones.size() != 0) @(posedge clk);
	endtask

	task automatic set_tick(input logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.tick_us = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic play_song();
		int k, base, n, end_n;
		k    = $urandom_range(1, 6);
		base = $urandom_range(0, 63);
		for (n = 0; n < k; n++)
			push_item(mk(REQ_WRITE, 1'($urandom), 6'($urandom), 7'($urandom),
				6'((base + n) % 64), rand_pitch(), rand_length()));
		end_n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : base + k;
		if (sb.running)
			push_item(mk(REQ_TICK, 1'b0, 6'($urandom), 7'($urandom), 6'($urandom),
				7'($urandom), 7'($urandom)));
		push_item(mk(REQ_TICK, 1'b1, 6'(base), 7'(end_n), 6'($urandom), 7'($urandom),
			7'($urandom)));
		n = 0;
		while (sb.running && n < 200) begin
			if ($urandom_range(0, 19) == 0)
				push_item(mk(REQ_WRITE, 1'($urandom), 6'($urandom), 7'($urandom),
					6'((base + $urandom_range(0, k - 1)) % 64), rand_pitch(),
					rand_length()));
			else
				push_item(mk(REQ_TICK, $urandom_range(0, 49) != 0, 6'($urandom),
					7'(end_n), 6'($urandom), 7'($urandom), 7'($urandom)));
			n++;
		end
	endtask

	task automatic run_phase(input int count);
		int target;
		target = beats_sent + count;
		while (beats_sent < target) begin
			if ($urandom_range(0, 9) < 7) begin
				play_song();
			end else begin
				repeat ($urandom_range(5, 20)) push_item(rand_item());
			end
		end
	endtask

	task automatic tick_till_idle(input logic [6:0] end_n);
		int n;
		n = 0;
		while (sb.running && n < 40) begin
			push_item(mk(REQ_TICK, 1'b1, '0, end_n, '0, '0, '0));
			n++;
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: rest, clamped octave and beat, tone 9 as rest, reset tick length
		push_item(mk(REQ_WRITE, 1'b0, '0, '0, 6'd0,  7'd0,   7'd0));
		push_item(mk(REQ_WRITE, 1'b1, '1, '1, 6'd1,  7'd17,  7'd1));
		push_item(mk(REQ_WRITE, 1'b0, '0, '0, 6'd2,  7'd127, 7'd120));
		push_item(mk(REQ_WRITE, 1'b0, '0, '0, 6'd3,  7'd29,  7'd8));
		push_item(mk(REQ_WRITE, 1'b0, '0, '0, 6'd62, 7'd11,  7'd10));
		push_item(mk(REQ_WRITE, 1'b0, '0, '0, 6'd63, 7'd21,  7'd100));
		push_item(mk(REQ_TICK, 1'b0, 6'd0, 7'd4, '0, '0, '0));
		push_item(mk(REQ_TICK, 1'b1, 6'd0, 7'd4, '0, '0, '0));
		tick_till_idle(7'd4);
		// index runs past the store while still below end
		push_item(mk(REQ_TICK, 1'b1, 6'd62, 7'd127, '0, '0, '0));
		tick_till_idle(7'd127);
		// first note already at or past end
		push_item(mk(REQ_TICK, 1'b1, 6'd5, 7'd3, '0, '0, '0));
		tick_till_idle(7'd3);
		// enable drop mid-melody
		push_item(mk(REQ_TICK, 1'b1, 6'd0, 7'd4, '0, '0, '0));
		push_item(mk(REQ_TICK, 1'b1, 6'd0, 7'd4, '0, '0, '0));
		push_item(mk(REQ_TICK, 1'b0, 6'd0, 7'd4, '0, '0, '0));

		set_tick(16'd65535);
		hold_request = 1;
		run_phase(PHASE_BEATS);
		set_tick(16'd1);
		run_phase(PHASE_BEATS);
		set_tick(16'($urandom_range(2, 65534)));
		run_phase(PHASE_BEATS);
		set_tick(16'($urandom_range(2, 65534)));
		run_phase(PHASE_BEATS);
		set_tick(16'd65535);
		run_phase(PHASE_BEATS);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_tones.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/bms_pkg.sv
rtl/bms_ram.sv
rtl/buzzer_melody_sequencer.sv
verif/tb.sv
